FILE: rtl/lbps_pkg.sv
// Shared types and constants for the LED blink pattern sequencer.
package lbps_pkg;

  // Fixed field widths of the item and result channels
  localparam int LEVEL_W = 8;
  localparam int VALUE_W = 16;
  localparam int ENTRY_W = 4;
  localparam int PLEN_W  = 5;
  localparam int KIND_W  = 3;

  // Defaults for the top-level parameters
  localparam int PATTERN_DEPTH_DEF  = 16;
  localparam int DURATION_WIDTH_DEF = 16;

  // Level register value after reset
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 8'd1;

  // Command codes carried in the kind field
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 3'd0,
    KIND_SET   = 3'd1,
    KIND_ENTRY = 3'd2,
    KIND_BLINK = 3'd3,
    KIND_FLASH = 3'd4
  } kind_t;

  // One input item as held in the pipeline
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [ENTRY_W-1:0] entry_index;
    logic [PLEN_W-1:0]  pattern_length;
  } item_t;

  // One result item
  typedef struct packed {
    logic [LEVEL_W-1:0] drive_level;
    logic               level_written;
  } result_t;

endpackage

FILE: rtl/lbps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lbps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lbps_ctrl.sv
// Sequencer state and per-item update, pattern store access and forwarding.
module lbps_ctrl
  import lbps_pkg::*;
#(
  parameter int PATTERN_DEPTH  = PATTERN_DEPTH_DEF,
  parameter int DURATION_WIDTH = DURATION_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_fire,
  input  logic                             commit,
  input  item_t                            item,
  input  logic [LEVEL_W-1:0]               max_level,
  input  logic [DURATION_WIDTH-1:0]        rd_data,
  output logic [$clog2(PATTERN_DEPTH)-1:0] rd_addr,
  output logic                             wr_en,
  output logic [$clog2(PATTERN_DEPTH)-1:0] wr_addr,
  output logic [DURATION_WIDTH-1:0]        wr_data,
  output result_t                          result
);

  localparam int AW = $clog2(PATTERN_DEPTH);
  localparam int SW = AW + 1;
  localparam int CW = (SW > PLEN_W) ? SW : PLEN_W;
  localparam int DW = DURATION_WIDTH;

  logic [AW-1:0]      step_index,   step_index_next;
  logic [SW-1:0]      steps_in_use, steps_in_use_next;
  logic [DW-1:0]      wait_count,   wait_count_next;
  logic               blink_active, blink_active_next;
  logic               flash_active, flash_active_next;
  logic [LEVEL_W-1:0] level_now,    level_now_next;
  logic               entry1_zero,  entry1_zero_next;
  logic               fwd_valid,    fwd_valid_next;
  logic [DW-1:0]      fwd_data,     fwd_data_next;

  logic [DW-1:0]      dur_in;
  logic [DW-1:0]      dur_now;
  logic [CW-1:0]      plen_clamp;
  logic [SW-1:0]      idx_inc;
  logic [LEVEL_W-1:0] step_level;
  logic               written;

  assign dur_in  = DW'(item.value);
  // Entry 1 after a flash reads as zero until rewritten; writes in flight forward
  assign dur_now = fwd_valid ? fwd_data : rd_data;
  assign idx_inc = SW'(step_index) + SW'(1);
  assign step_level = step_index[0] ? '0 : max_level;

  // Start blink length kept within one and the store depth
  always_comb begin
    plen_clamp = CW'(item.pattern_length);
    if (plen_clamp == '0) begin
      plen_clamp = CW'(1);
    end else if (plen_clamp > CW'(PATTERN_DEPTH)) begin
      plen_clamp = CW'(PATTERN_DEPTH);
    end
  end

  // Item update, applied only when the item leaves the pipeline register
  always_comb begin
    step_index_next   = step_index;
    steps_in_use_next = steps_in_use;
    wait_count_next   = wait_count;
    blink_active_next = blink_active;
    flash_active_next = flash_active;
    level_now_next    = level_now;
    entry1_zero_next  = entry1_zero;
    wr_en             = 1'b0;
    wr_addr           = '0;
    wr_data           = dur_in;
    written           = 1'b0;
    if (commit) begin
      unique case (item.kind)
        KIND_SET: begin
          blink_active_next = 1'b0;
          flash_active_next = 1'b0;
          level_now_next = (item.value > VALUE_W'(max_level)) ? max_level
                                                             : item.value[LEVEL_W-1:0];
          written = 1'b1;
        end
        KIND_ENTRY: begin
          if (32'(item.entry_index) < PATTERN_DEPTH) begin
            wr_en   = 1'b1;
            wr_addr = AW'(item.entry_index);
            if (AW'(item.entry_index) == AW'(1)) begin
              entry1_zero_next = 1'b0;
            end
          end
        end
        KIND_BLINK: begin
          steps_in_use_next = SW'(plen_clamp);
          step_index_next   = '0;
          wait_count_next   = '0;
          blink_active_next = 1'b1;
          flash_active_next = 1'b0;
        end
        KIND_FLASH: begin
          wr_en             = 1'b1;
          wr_addr           = '0;
          entry1_zero_next  = 1'b1;
          steps_in_use_next = SW'(2);
          step_index_next   = '0;
          wait_count_next   = '0;
          blink_active_next = 1'b0;
          flash_active_next = 1'b1;
        end
        KIND_TICK: begin
          if (blink_active || flash_active) begin
            if (wait_count <= DW'(1)) begin
              wait_count_next = dur_now;
              step_index_next = (idx_inc == steps_in_use) ? '0 : idx_inc[AW-1:0];
              if (flash_active && (step_level == '0)) begin
                flash_active_next = 1'b0;
              end
              level_now_next = step_level;
              written        = 1'b1;
            end else begin
              wait_count_next = wait_count - DW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Next item reads the entry of the step it will see
  assign rd_addr = step_index_next;

  // Forward a write landing on the entry being read this cycle
  always_comb begin
    fwd_valid_next = 1'b0;
    fwd_data_next  = '0;
    if (wr_en && (wr_addr == rd_addr)) begin
      fwd_valid_next = 1'b1;
      fwd_data_next  = wr_data;
    end else if (entry1_zero_next && (rd_addr == AW'(1))) begin
      fwd_valid_next = 1'b1;
    end
  end

  assign result.drive_level   = level_now_next;
  assign result.level_written = written;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_index   <= '0;
      steps_in_use <= SW'(1);
      wait_count   <= '0;
      blink_active <= 1'b0;
      flash_active <= 1'b0;
      level_now    <= '0;
      entry1_zero  <= 1'b0;
      fwd_valid    <= 1'b0;
    end else begin
      step_index   <= step_index_next;
      steps_in_use <= steps_in_use_next;
      wait_count   <= wait_count_next;
      blink_active <= blink_active_next;
      flash_active <= flash_active_next;
      level_now    <= level_now_next;
      entry1_zero  <= entry1_zero_next;
      if (in_fire) begin
        fwd_valid <= fwd_valid_next;
      end
    end
  end

  // Forwarded data travels with the read it replaces
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_data <= fwd_data_next;
    end
  end

endmodule

FILE: rtl/led_blink_pattern_sequencer.sv
// Top level of the LED blink pattern sequencer.
//
// Input channel (in_valid/in_ready) takes one command item per cycle while
// the output is not stalled: a 1 ms tick, a set level, a pattern entry
// write, start blink or start flash. Every item yields exactly one result
// item on the output channel (out_valid/out_ready): the level now driven and
// whether this item drove it. The config channel
// (cfg_valid/cfg_ready/cfg_data) writes max_level; it is always ready, and the
// user must write it only while no item is in flight; the block itself does
// not enforce this. An accepted item waits in the pipeline register, where
// the store read issued at acceptance returns, until the output can take it.
// Throughput: one item per cycle, until the receiver stalls. The pattern store
// read for the next item is issued in the same cycle the current item updates
// the step index, and writes to the entry being read are forwarded.
// Reset clears the sequencer to idle with the LED at 0 and max_level at 1;
// the pattern store is not cleared and must be written before it is used.
// When the receiver stalls, the finished result holds in the output register,
// one more item waits in the pipeline register, and in_ready then drops.
module led_blink_pattern_sequencer
  import lbps_pkg::*;
#(
  parameter int PATTERN_DEPTH  = PATTERN_DEPTH_DEF,
  parameter int DURATION_WIDTH = DURATION_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  kind,
  input  logic [VALUE_W-1:0] value,
  input  logic [ENTRY_W-1:0] entry_index,
  input  logic [PLEN_W-1:0]  pattern_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] drive_level,
  output logic               level_written,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEVEL_W-1:0] cfg_data
);

  localparam int AW = $clog2(PATTERN_DEPTH);

  logic               p1_valid;
  item_t              p1_item;
  logic               out_free;
  logic               commit;
  logic               in_fire;
  logic [LEVEL_W-1:0] max_level;
  result_t            result;
  result_t            out_res;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [DURATION_WIDTH-1:0] wr_data;
  logic [AW-1:0]             rd_addr;
  logic [DURATION_WIDTH-1:0] rd_data;

  // Handshake: pipeline register feeds the output register
  assign out_free  = !out_valid || out_ready;
  assign commit    = p1_valid && out_free;
  assign in_ready  = !p1_valid || out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
      max_level <= MAX_LEVEL_RST;
    end else begin
      if (in_ready) begin
        p1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= p1_valid;
      end
      if (cfg_valid) begin
        max_level <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_item <= '{kind: kind, value: value, entry_index: entry_index,
                   pattern_length: pattern_length};
    end
    if (commit) begin
      out_res <= result;
    end
  end

  assign drive_level   = out_res.drive_level;
  assign level_written = out_res.level_written;

  lbps_ctrl #(
    .PATTERN_DEPTH  (PATTERN_DEPTH),
    .DURATION_WIDTH (DURATION_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .commit    (commit),
    .item      (p1_item),
    .max_level (max_level),
    .rd_data   (rd_data),
    .rd_addr   (rd_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .result    (result)
  );

  lbps_ram #(
    .WIDTH (DURATION_WIDTH),
    .DEPTH (PATTERN_DEPTH)
  ) u_pattern_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

FILE: sim/led_level_monitor.sv
// Channel monitor for the LED sequencer: predicts each result item and compares it.
`timescale 1ns / 1ps
module led_level_monitor
  import lbps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [KIND_W-1:0]  kind,
  input  logic [VALUE_W-1:0] value,
  input  logic [ENTRY_W-1:0] entry_index,
  input  logic [PLEN_W-1:0]  pattern_length,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [LEVEL_W-1:0] drive_level,
  input  logic               level_written,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [LEVEL_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int DEPTH = PATTERN_DEPTH_DEF;

  // Shadow copy of the sequencer state
  logic [VALUE_W-1:0] dur_table [DEPTH];
  logic [ENTRY_W-1:0] step_idx;
  logic [PLEN_W-1:0]  steps_used;
  logic [VALUE_W-1:0] wait_ms;
  logic               blinking;
  logic               flashing;
  logic [LEVEL_W-1:0] led_level;
  logic [LEVEL_W-1:0] max_level;

  // Levels still owed by the block, oldest first
  result_t            led_expected_q[$];
  result_t            owed;

  // Apply one command to the shadow state and return the level it leaves
  function automatic result_t next_led_level(input logic [KIND_W-1:0]  k,
                                             input logic [VALUE_W-1:0] v,
                                             input logic [ENTRY_W-1:0] e,
                                             input logic [PLEN_W-1:0]  p);
    result_t            r;
    int                 len;
    int                 nxt;
    logic [LEVEL_W-1:0] lvl;
    r.level_written = 1'b0;
    case (k)
      KIND_SET: begin
        blinking = 1'b0;
        flashing = 1'b0;
        led_level = (v > max_level) ? max_level : v[LEVEL_W-1:0];
        r.level_written = 1'b1;
      end
      KIND_ENTRY: begin
        dur_table[e] = v;
      end
      KIND_BLINK: begin
        // zero length means one step, oversize saturates to the store depth
        len = (p == 0) ? 1 : ((p > DEPTH) ? DEPTH : int'(p));
        steps_used = len[PLEN_W-1:0];
        step_idx = '0;
        wait_ms = '0;
        blinking = 1'b1;
        flashing = 1'b0;
      end
      KIND_FLASH: begin
        // on for the duration, then one off step ends the flash
        dur_table[0] = v;
        dur_table[1] = '0;
        steps_used = 5'd2;
        step_idx = '0;
        wait_ms = '0;
        blinking = 1'b0;
        flashing = 1'b1;
      end
      KIND_TICK: begin
        if (blinking || flashing) begin
          if (wait_ms <= 1) begin
            lvl = step_idx[0] ? '0 : max_level;
            wait_ms = dur_table[step_idx];
            nxt = (int'(step_idx) + 1) % int'(steps_used);
            step_idx = nxt[ENTRY_W-1:0];
            if (flashing && lvl == 0)
              flashing = 1'b0;
            led_level = lvl;
            r.level_written = 1'b1;
          end else begin
            wait_ms = wait_ms - 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.drive_level = led_level;
    return r;
  endfunction

  // Sample all three channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      step_idx = '0;
      steps_used = 5'd1;
      wait_ms = '0;
      blinking = 1'b0;
      flashing = 1'b0;
      led_level = '0;
      max_level = MAX_LEVEL_RST;
      led_expected_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        max_level = cfg_data;
      if (in_valid && in_ready)
        led_expected_q.push_back(next_led_level(kind, value, entry_index, pattern_length));
      if (out_valid && out_ready) begin
        if (led_expected_q.size() == 0) begin
          $error("drive_level: no item outstanding, got %0d (level_written %0d)",
                 drive_level, level_written);
          fail_count = fail_count + 1;
        end else begin
          owed = led_expected_q.pop_front();
          if (drive_level !== owed.drive_level) begin
            $error("drive_level: expected %0d, got %0d", owed.drive_level, drive_level);
            fail_count = fail_count + 1;
          end
          if (level_written !== owed.level_written) begin
            $error("level_written: expected %0d, got %0d",
                   owed.level_written, level_written);
            fail_count = fail_count + 1;
          end
        end
      end
      pending <= led_expected_q.size();
    end
  end

endmodule

FILE: sim/led_blink_pattern_sequencer_test.sv
// Top of the LED sequencer testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module led_blink_pattern_sequencer_test
  import lbps_pkg::*;
;

  localparam int ITEM_TARGET      = 1050;
  localparam int PHASES           = 5;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DEPTH            = PATTERN_DEPTH_DEF;

  // Kind codes the block must ignore
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KIND_W-1:0]  kind = '0;
  logic [VALUE_W-1:0] value = '0;
  logic [ENTRY_W-1:0] entry_index = '0;
  logic [PLEN_W-1:0]  pattern_length = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [LEVEL_W-1:0] drive_level;
  logic               level_written;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LEVEL_W-1:0] cfg_data = '0;

  int                 fail_count;
  int                 pending;
  int                 cycles = 0;
  int                 sent_items = 0;
  int                 directed_items = 0;
  int                 tick_count = 0;
  int                 set_count = 0;
  int                 blink_count = 0;
  int                 flash_count = 0;
  int                 cfg_count = 0;
  logic [DEPTH-1:0]   entry_set = '0;
  bit                 calm = 1'b0;
  bit                 long_hold = 1'b0;

  led_blink_pattern_sequencer DUT (.*);

  led_level_monitor level_monitor (.*);

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one item and wait until it is taken
  task automatic send(input logic [KIND_W-1:0]  k,
                      input logic [VALUE_W-1:0] v,
                      input logic [ENTRY_W-1:0] e,
                      input logic [PLEN_W-1:0]  p);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    value <= v;
    entry_index <= e;
    pattern_length <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
    case (k)
      KIND_TICK:  tick_count++;
      KIND_SET:   set_count++;
      KIND_BLINK: blink_count++;
      KIND_FLASH: begin
        flash_count++;
        entry_set[1:0] = 2'b11;
      end
      KIND_ENTRY: entry_set[e] = 1'b1;
      default: ;
    endcase
  endtask

  task automatic tick();
    send(KIND_TICK, VALUE_W'($urandom_range(0, 65535)), ENTRY_W'($urandom_range(0, 15)),
         PLEN_W'($urandom_range(0, 31)));
  endtask

  // Drop valid, wait for every owed result, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_level(input logic [LEVEL_W-1:0] lvl);
    cfg_valid <= 1'b1;
    cfg_data <= lvl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_count++;
  endtask

  // Length of the run of written entries, counted up from entry 0
  function automatic int written_run();
    int n;
    n = 0;
    while (n < DEPTH && entry_set[n]) n++;
    return n;
  endfunction

  // Mostly short durations so patterns actually step
  function automatic logic [VALUE_W-1:0] pick_duration();
    case ($urandom_range(0, 31))
      0:          return VALUE_W'($urandom_range(0, 65535));
      1, 2, 3, 4: return VALUE_W'($urandom_range(5, 40));
      default:    return VALUE_W'($urandom_range(0, 4));
    endcase
  endfunction

  // Start blink over len entries, sometimes through the zero or oversize encodings
  task automatic start_blink(input int len);
    logic [PLEN_W-1:0] p;
    p = PLEN_W'(len);
    if (len == 1 && $urandom_range(0, 2) == 0)
      p = '0;
    else if (len == DEPTH && $urandom_range(0, 1) == 0)
      p = PLEN_W'($urandom_range(DEPTH + 1, 31));
    send(KIND_BLINK, VALUE_W'($urandom_range(0, 65535)), ENTRY_W'($urandom_range(0, 15)), p);
  endtask

  // Any kind with random fields; blink only over entries already written
  task automatic random_noise();
    logic [KIND_W-1:0] k;
    int                run;
    k = KIND_W'($urandom_range(0, 7));
    run = written_run();
    if (k == KIND_BLINK) begin
      if (run == 0)
        tick();
      else
        start_blink($urandom_range(1, run));
    end else if (k == KIND_ENTRY) begin
      send(k, pick_duration(), ENTRY_W'($urandom_range(0, 15)),
           PLEN_W'($urandom_range(0, 31)));
    end else begin
      send(k, VALUE_W'($urandom_range(0, 65535)), ENTRY_W'($urandom_range(0, 15)),
           PLEN_W'($urandom_range(0, 31)));
    end
  endtask

  // Mostly program-and-blink runs, some flashes, sets and stray items
  task automatic random_burst();
    int pick;
    int len;
    int n;
    pick = $urandom_range(0, 19);
    if (pick < 11) begin
      case ($urandom_range(0, 4))
        0:       len = DEPTH;
        1:       len = $urandom_range(1, DEPTH);
        default: len = $urandom_range(1, 5);
      endcase
      for (int i = 0; i < len; i++)
        send(KIND_ENTRY, pick_duration(), ENTRY_W'(i), PLEN_W'($urandom_range(0, 31)));
      start_blink(len);
      n = $urandom_range(4, 40);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 14) == 0)
          random_noise();
        else
          tick();
      end
    end else if (pick < 15) begin
      send(KIND_FLASH, pick_duration(), ENTRY_W'($urandom_range(0, 15)),
           PLEN_W'($urandom_range(0, 31)));
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) tick();
    end else if (pick < 17) begin
      send(KIND_SET, VALUE_W'($urandom_range(0, 65535)), ENTRY_W'($urandom_range(0, 15)),
           PLEN_W'($urandom_range(0, 31)));
    end else begin
      random_noise();
    end
  endtask

  // Main stimulus
  initial begin
    int                 phase_target;
    bit                 paused;
    logic [LEVEL_W-1:0] lvl;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_max_level(8'd200);

    // Directed: idle tick, ignored kinds, set clamp and zero
    tick();
    send(KIND_SPARE_LO, 16'hA5A5, 4'hF, 5'h1F);
    send(KIND_SPARE_HI, 16'h5A5A, 4'h0, 5'h00);
    send(KIND_SET, 16'hFFFF, 4'h0, 5'h00);
    send(KIND_SET, 16'h0000, 4'hF, 5'h1F);
    // pattern with a zero duration; the last entry gets the longest duration
    send(KIND_ENTRY, 16'd0, 4'd0, 5'd0);
    send(KIND_ENTRY, 16'd2, 4'd1, 5'd0);
    send(KIND_ENTRY, 16'd1, 4'd2, 5'd0);
    send(KIND_ENTRY, 16'd3, 4'd3, 5'd0);
    send(KIND_ENTRY, 16'hFFFF, 4'd15, 5'd0);
    // zero length acts as one step
    send(KIND_BLINK, 16'd0, 4'd0, 5'd0);
    tick();
    tick();
    send(KIND_BLINK, 16'd0, 4'd0, 5'd4);
    repeat (5) tick();
    // zero-length flash: on, then off, then idle
    send(KIND_FLASH, 16'd0, 4'd0, 5'd0);
    repeat (3) tick();
    // longest flash, cut short by a set
    send(KIND_FLASH, 16'hFFFF, 4'd0, 5'd0);
    tick();
    send(KIND_SET, 16'd255, 4'd0, 5'd0);
    directed_items = sent_items;

    // Random phases, each under its own max_level
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       lvl = 8'd0;
        1:       lvl = 8'd255;
        2:       lvl = 8'd1;
        default: lvl = LEVEL_W'($urandom_range(2, 254));
      endcase
      write_max_level(lvl);
      calm = (ph == PHASES - 1);
      if (ph == 1)
        long_hold = 1'b1;
      phase_target = directed_items + (ph + 1) * (ITEM_TARGET - directed_items) / PHASES;
      while (sent_items < phase_target) begin
        random_burst();
        // one full drain in mid-run
        if (ph == 2 && !paused && sent_items >= phase_target - 100) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Ran %0d items (%0d directed): %0d ticks, %0d sets, %0d blinks, %0d flashes.",
             sent_items, directed_items, tick_count, set_count, blink_count, flash_count);
    $display("max_level written %0d times (0, 1, 200, 255 and random); one %0d-cycle output hold.",
             cfg_count, LONG_HOLD_CYCLES);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lbps_pkg.sv
rtl/lbps_ram.sv
rtl/lbps_ctrl.sv
rtl/led_blink_pattern_sequencer.sv
sim/led_level_monitor.sv
sim/led_blink_pattern_sequencer_test.sv
